// ===== hdl/spi_mrt_pkg.sv =====
// Shared types and constants for the SPI master register transfer block.
package spi_mrt_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned BIT_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CFG_DELAY_WIDTH = 16;
   localparam logic [CFG_DELAY_WIDTH-1:0] DELAY_RESET = 16'd10;

   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_END   = 3'd4;

   localparam logic [1:0] REG_CLOCK_POLARITY   = 2'd0;
   localparam logic [1:0] REG_CLOCK_PHASE      = 2'd1;
   localparam logic [1:0] REG_DELAY_TICKS      = 2'd2;
   localparam logic [1:0] REG_EXCHANGE_ON_READ = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_BIT_A = 5'b00100,
      PH_BIT_D = 5'b01000,
      PH_BIT_B = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [2:0]           mode;
      logic [BYTE_BITS-1:0] tx_byte;
      logic                 miso;
   } req_type;

   typedef struct packed {
      logic                 sck;
      logic                 mosi;
      logic                 cs_n;
      logic                 ready_res;
      logic                 rx_valid;
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 cmd_rejected;
   } rsp_type;

   typedef struct packed {
      logic                       clock_polarity;
      logic                       clock_phase;
      logic [CFG_DELAY_WIDTH-1:0] delay_ticks;
      logic                       exchange_on_read;
   } cfg_type;

endpackage

// ===== hdl/spi_mrt_csr.sv =====
// APB-style configuration registers of the SPI master.
module spi_mrt_csr
   import spi_mrt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_CLOCK_POLARITY:   cfg_in.clock_polarity   = pwdata[0];
            REG_CLOCK_PHASE:      cfg_in.clock_phase      = pwdata[0];
            REG_DELAY_TICKS:      cfg_in.delay_ticks      = pwdata[CFG_DELAY_WIDTH-1:0];
            REG_EXCHANGE_ON_READ: cfg_in.exchange_on_read = pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CLOCK_POLARITY:   prdata = CSR_DATA_WIDTH'(cfg_ff.clock_polarity);
         REG_CLOCK_PHASE:      prdata = CSR_DATA_WIDTH'(cfg_ff.clock_phase);
         REG_DELAY_TICKS:      prdata = CSR_DATA_WIDTH'(cfg_ff.delay_ticks);
         REG_EXCHANGE_ON_READ: prdata = CSR_DATA_WIDTH'(cfg_ff.exchange_on_read);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_polarity   <= 1'b0;
         cfg_ff.clock_phase      <= 1'b0;
         cfg_ff.delay_ticks      <= DELAY_RESET;
         cfg_ff.exchange_on_read <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/spi_mrt_seq.sv =====
// SPI pin sequencer: one tick of state advance per accepted beat.
module spi_mrt_seq
   import spi_mrt_pkg::*;
#(
   parameter int unsigned DELAY_WIDTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   phase_type                  phase_ff, phase_in;
   logic                       sck_ff, sck_in;
   logic                       mosi_ff, mosi_in;
   logic                       cs_n_ff, cs_n_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic [DELAY_WIDTH-1:0]     wait_ff, wait_in;
   logic [BYTE_BITS-1:0]       send_ff, send_in;
   logic [BYTE_BITS-1:0]       recv_ff, recv_in;

   logic [DELAY_WIDTH-1:0]     delay_masked;
   logic [DELAY_WIDTH-1:0]     slot;
   logic [DELAY_WIDTH-1:0]     wait_dec;
   logic                       level_a;
   logic                       is_cmd;
   logic [BYTE_BITS-1:0]       recv_next;

   assign delay_masked = DELAY_WIDTH'(cfg.delay_ticks);
   assign slot         = (delay_masked == '0) ? DELAY_WIDTH'(1) : delay_masked;
   assign level_a      = cfg.clock_polarity ^ cfg.clock_phase;
   assign wait_dec     = wait_ff - DELAY_WIDTH'(1);
   assign recv_next    = {recv_ff[BYTE_BITS-2:0], req.miso};
   assign is_cmd       = (req.mode == MODE_START) || (req.mode == MODE_WRITE) ||
                         (req.mode == MODE_READ) || (req.mode == MODE_END);

   always_comb begin
      phase_in            = phase_ff;
      sck_in              = sck_ff;
      mosi_in             = mosi_ff;
      cs_n_in             = cs_n_ff;
      bit_index_in        = bit_index_ff;
      wait_in             = wait_ff;
      send_in             = send_ff;
      recv_in             = recv_ff;
      result.rx_valid     = 1'b0;
      result.rx_byte      = '0;
      result.cmd_rejected = 1'b0;
      if (phase_ff == PH_IDLE) begin
         case (req.mode)
            MODE_START: begin
               sck_in   = cfg.clock_polarity;
               cs_n_in  = 1'b0;
               wait_in  = slot;
               phase_in = PH_START;
            end
            MODE_WRITE, MODE_READ: begin
               if (req.mode == MODE_READ && !cfg.exchange_on_read) begin
                  send_in = '1;
               end else begin
                  send_in = req.tx_byte;
               end
               recv_in      = '0;
               bit_index_in = BIT_INDEX_WIDTH'(BYTE_BITS - 1);
               sck_in       = level_a;
               wait_in      = slot;
               phase_in     = PH_BIT_A;
            end
            MODE_END: begin
               sck_in  = cfg.clock_polarity;
               cs_n_in = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end else begin
         result.cmd_rejected = is_cmd;
         wait_in             = wait_dec;
         if (wait_dec == '0) begin
            case (phase_ff)
               PH_START: begin
                  phase_in = PH_IDLE;
               end
               PH_BIT_A: begin
                  mosi_in  = send_ff[BYTE_BITS-1];
                  wait_in  = slot;
                  phase_in = PH_BIT_D;
               end
               PH_BIT_D: begin
                  sck_in   = ~level_a;
                  wait_in  = slot;
                  phase_in = PH_BIT_B;
               end
               PH_BIT_B: begin
                  recv_in = recv_next;
                  sck_in  = level_a;
                  if (bit_index_ff == '0) begin
                     result.rx_valid = 1'b1;
                     result.rx_byte  = recv_next;
                     phase_in        = PH_IDLE;
                  end else begin
                     bit_index_in = bit_index_ff - BIT_INDEX_WIDTH'(1);
                     send_in      = {send_ff[BYTE_BITS-2:0], 1'b0};
                     wait_in      = slot;
                     phase_in     = PH_BIT_A;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      result.sck       = sck_in;
      result.mosi      = mosi_in;
      result.cs_n      = cs_n_in;
      result.ready_res = (phase_in == PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         sck_ff       <= 1'b0;
         mosi_ff      <= 1'b1;
         cs_n_ff      <= 1'b1;
         bit_index_ff <= '0;
         wait_ff      <= '0;
         send_ff      <= '0;
         recv_ff      <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         sck_ff       <= sck_in;
         mosi_ff      <= mosi_in;
         cs_n_ff      <= cs_n_in;
         bit_index_ff <= bit_index_in;
         wait_ff      <= wait_in;
         send_ff      <= send_in;
         recv_ff      <= recv_in;
      end
   end

endmodule

// ===== hdl/spi_master_register_transfer.sv =====
// Top level of the SPI master register transfer block.
//
// Each req beat is one clock tick of an SPI pin sequencer: it carries a
// command (none, start, write byte, read byte, end), the byte to send and
// the sampled MISO level. Each req beat yields exactly one rsp beat with
// the SCK, MOSI and chip select levels after that tick, the idle flag,
// a received byte strobe and a command rejected flag.
// Configuration (polarity, phase, delay per slot, exchange on read) is
// written through the APB-style port; the user must write it only while
// no beat is in flight, which the block does not enforce. Throughput:
// one beat per cycle while req_ready is high; the sequencer state
// advances in a single pass of logic per beat. A two-entry rsp buffer
// (output register plus skid register) registers each accepted beat;
// req_ready comes from a register and drops only when both entries are
// full, so a stall on rsp holds req after one more beat.
// Reset clears the sequencer to idle with SCK low, MOSI high and chip
// select high, loads the configuration defaults and empties the buffer.
module spi_master_register_transfer
   import spi_mrt_pkg::*;
#(
   parameter int unsigned DELAY_WIDTH = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type cfg;
   rsp_type step_result;
   logic    accept;
   logic    pop;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   spi_mrt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   spi_mrt_seq #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .req    (req_data),
      .cfg    (cfg),
      .result (step_result)
   );

   assign req_ready = ~skid_valid_ff;
   assign accept    = req_valid & req_ready;
   assign pop       = out_valid_ff & rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && pop) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = step_result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = step_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== hdl/spi_mrt_checker.sv =====
// Port-level assertions for the SPI master register transfer block.
module spi_mrt_checker
   import spi_mrt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat present right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req held off while no rsp beat waits");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rx_valid |-> rsp_data.rx_byte == '0)
      else $error("rx_byte set without rx_valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_valid |-> rsp_data.ready_res && !rsp_data.cmd_rejected
         || rsp_valid && rsp_data.rx_valid && rsp_data.ready_res)
      else $error("byte completion did not return sequencer to idle");

endmodule

bind spi_master_register_transfer spi_mrt_checker u_spi_mrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
